// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the given reset is asserted.
`define DPSE_ASSERT_CLK(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Same check on the default clock and reset names of this block.
`define DPSE_ASSERT(lbl, prop) \
	`DPSE_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

// ===== rtl/dpse_pkg.sv =====
package dpse_pkg;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 15;
	localparam int LEN_W    = 4;
	localparam int CODE_W   = 20;
	localparam int ACC_W    = 27;
	localparam int TOTAL_W  = 5;
	localparam int PEND_W   = 7;
	localparam int PCNT_W   = 3;
	localparam int NBYTE_W  = 3;
	localparam int LANES    = 4;

	// One input beat.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} in_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} out_t;

	// Packed bytes of one coded sample, as queued between front and back.
	typedef struct packed {
		logic [LANES-1:0][7:0] bytes;
		logic [NBYTE_W-1:0]    nbytes;
		logic                  last;
	} word_t;

endpackage

// ===== rtl/dpse_front.sv =====
module dpse_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  dpse_pkg::in_t item,
	output logic          q_push,
	input  logic          q_full,
	output dpse_pkg::word_t q_word
);

	logic [dpse_pkg::SAMPLE_W-1:0] prev_q, older_q;
	logic [dpse_pkg::PEND_W-1:0]   pend_q;
	logic [dpse_pkg::PCNT_W-1:0]   pcnt_q;

	logic [dpse_pkg::SAMPLE_W-1:0] smp, pred, err;
	logic                          neg;
	logic [dpse_pkg::MAG_W-1:0]    mag, mask;
	logic [dpse_pkg::LEN_W-1:0]    n;
	logic [dpse_pkg::CODE_W-1:0]   code;
	logic [dpse_pkg::ACC_W-1:0]    acc, shifted;
	logic [dpse_pkg::TOTAL_W-1:0]  total;
	logic [1:0]                    full_bytes;
	logic [2:0]                    rem;
	logic                          flush;
	logic [dpse_pkg::NBYTE_W-1:0]  nbytes;
	logic                          accept;

	assign smp  = item.sample;
	assign pred = {prev_q[dpse_pkg::SAMPLE_W-2:0], 1'b0} - older_q;
	assign err  = smp - pred;
	assign neg  = err[dpse_pkg::SAMPLE_W-1];
	assign mag  = neg ? ~err[dpse_pkg::MAG_W-1:0] : err[dpse_pkg::MAG_W-1:0];

	// Bit length of the magnitude: one past the highest set bit.
	always_comb begin
		n = '0;
		for (int i = 0; i < dpse_pkg::MAG_W; i++) begin
			if (mag[i])
				n = dpse_pkg::LEN_W'(i + 1);
		end
	end

	assign mask  = dpse_pkg::MAG_W'((16'd1 << n) - 16'd1);
	assign code  = {err[dpse_pkg::MAG_W-1:0] & mask, neg, n};
	assign acc   = {{(dpse_pkg::ACC_W-dpse_pkg::PEND_W){1'b0}}, pend_q}
		| (dpse_pkg::ACC_W'(code) << pcnt_q);
	assign total = dpse_pkg::TOTAL_W'(pcnt_q) + dpse_pkg::TOTAL_W'(5)
		+ dpse_pkg::TOTAL_W'(n);

	assign full_bytes = total[4:3];
	assign rem        = total[2:0];
	assign flush      = item.last_sample && (rem != 3'd0);
	assign nbytes     = dpse_pkg::NBYTE_W'(full_bytes) + dpse_pkg::NBYTE_W'(flush);
	assign shifted    = acc >> {full_bytes, 3'b000};

	assign accept = push && !q_full;
	assign full   = q_full;
	assign q_push = accept && (nbytes != '0);

	always_comb begin
		q_word.bytes  = 32'(acc);
		q_word.nbytes = nbytes;
		q_word.last   = item.last_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			older_q <= '0;
			pend_q  <= '0;
			pcnt_q  <= '0;
		end else if (accept) begin
			if (item.last_sample) begin
				prev_q  <= '0;
				older_q <= '0;
				pend_q  <= '0;
				pcnt_q  <= '0;
			end else begin
				prev_q  <= smp;
				older_q <= prev_q;
				pend_q  <= shifted[dpse_pkg::PEND_W-1:0];
				pcnt_q  <= rem;
			end
		end
	end

endmodule

// ===== rtl/dpse_fifo.sv =====
module dpse_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  dpse_pkg::word_t din,
	output logic            full,
	input  logic            rd,
	output dpse_pkg::word_t dout,
	output logic            empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	dpse_pkg::word_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr_en, rd_en;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_en = wr && !full;
	assign rd_en = rd && !empty;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/dpse_back.sv =====
module dpse_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  dpse_pkg::word_t q_word,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output dpse_pkg::out_t  result
);

	dpse_pkg::word_t cur_q;
	logic            valid_q;
	logic [1:0]      idx_q;
	logic            at_end, take;

	// The byte on show is the final one of its word.
	assign at_end = (dpse_pkg::NBYTE_W'(idx_q) + 1'b1 == cur_q.nbytes);
	assign take   = pop && valid_q;
	assign q_pop  = !q_empty && (!valid_q || (take && at_end));

	assign empty            = !valid_q;
	assign result.out_byte  = cur_q.bytes[idx_q];
	assign result.last_byte = cur_q.last && at_end;

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (at_end)
				valid_q <= 1'b0;
			else
				idx_q <= idx_q + 1'b1;
		end
	end

endmodule

// ===== rtl/delta_predictor_sample_encoder_unit.sv =====
// Second-order predictor audio encoder with LSB-first bit packing.
// Input channel: item carries one 16-bit signed sample and a last_sample flag;
// a beat is taken at a clock edge where push is high and full is low.
// Result channel: result carries one packed byte and a last_byte flag; the
// oldest byte is shown while empty is low and leaves on an edge with pop high.
// Each sample is coded combinationally by the front end (prediction error,
// length, sign, value bits, merge with the pending bits) into a word of zero
// to four bytes, which waits in a small queue of QUEUE_DEPTH words.
// The back end shows the bytes of the head word one per cycle while pop is high.
// A coded word passes the queue and then the back end's word register before
// its bytes are shown. Throughput: one sample per cycle while the queue has room;
// sustained, one byte per cycle on the result side while pop is high; a sample
// produces zero to three bytes, four when a last sample flushes.
// A stalled receiver first fills the queue; full then rises and holds the
// sender off, and nothing is dropped. A last sample ends the stream with a last_byte
// byte, zero-padded if partial, and clears the predictor and pending bits.
// Reset clears the predictor history, the pending bits and the queue; empty
// is high and full is low once reset is released.
module delta_predictor_sample_encoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  dpse_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output dpse_pkg::out_t result
);

	// Front-to-queue and queue-to-back word paths.
	dpse_pkg::word_t f_word, b_word;
	logic            f_push, q_full, q_empty, b_pop;

	// Front end: predictor, coder and bit accumulator.
	dpse_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (f_push),
		.q_full (q_full),
		.q_word (f_word)
	);

	// Decoupling queue of coded words.
	dpse_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.din    (f_word),
		.full   (q_full),
		.rd     (b_pop),
		.dout   (b_word),
		.empty  (q_empty)
	);

	// Back end: serializes each word into result beats.
	dpse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_word  (b_word),
		.q_pop   (b_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== rtl/dpse_checker.sv =====
`include "assert_macros.svh"

module dpse_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           push,
	input logic           full,
	input dpse_pkg::in_t  item,
	input logic           empty,
	input logic           pop,
	input dpse_pkg::out_t result
);

	// Coming out of reset the block holds nothing and takes input.
	`DPSE_ASSERT(a_reset_idle, $rose(arst_n) |-> (empty && !full))

	// A full queue means the back end already shows a byte.
	`DPSE_ASSERT(a_full_not_empty, full |-> !empty)

	// A shown byte that is not taken stays, unchanged.
	`DPSE_ASSERT(a_stall_hold, (!empty && !pop) |=> (!empty && $stable(result)))

	// A last byte that is taken is followed by full low: taking it leaves room
	// for input.
	`DPSE_ASSERT(a_last_frees, (!empty && pop && result.last_byte) |=> !full)

endmodule

bind delta_predictor_sample_encoder_unit dpse_checker u_dpse_checker (.*);
